// ===== rtl/core/tickless_ms_timekeeper_assert.svh =====
// Assertion macros for the timekeeper RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TICKLESS_MS_TIMEKEEPER_ASSERT_SVH
`define TICKLESS_MS_TIMEKEEPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define TMK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TMK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tmk_pkg.sv =====
// Types, constants and conversion tables for the millisecond timekeeper.
// No dependencies; imported by tmk_csr, tmk_update, the top level and the testbench.
`timescale 1ns / 1ps

package tmk_pkg;

   // Event kinds and tick modes
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SWITCH = 1'b1;
   localparam logic TICK_RUN    = 1'b0;
   localparam logic TICK_SLEEP  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_REPORT_ENABLE = 1'b0;
   localparam logic CSR_WRAP_LIMIT    = 1'b1;

   localparam logic [31:0] WRAP_LIMIT_RESET = 32'd1800000;

   // Timer constants
   localparam int RUN_RELOAD   = 249;
   localparam int SLEEP_RELOAD = 58;
   localparam int RUN_CLK_HZ   = 250000;
   localparam int SLEEP_CLK_HZ = 38000 / 64;
   localparam int HUND_SCALE   = 100000;

   localparam int HUND_WIDTH = 14;
   localparam int FRAC_WIDTH = 7;

   localparam logic [7:0] RUN_RELOAD_V   = 8'(RUN_RELOAD);
   localparam logic [7:0] SLEEP_RELOAD_V = 8'(SLEEP_RELOAD);

   // Hundredths gained by one sleep tick
   localparam logic [HUND_WIDTH-1:0] SLEEP_TICK_HUND =
      HUND_WIDTH'(((SLEEP_RELOAD + 1) * HUND_SCALE) / SLEEP_CLK_HZ);

   // Divide by 100 through a reciprocal; exact for values below 2^14
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef logic [HUND_WIDTH-1:0] hund_lut_type [256];

   typedef struct packed {
      logic       mode;
      logic       new_mode;
      logic [7:0] counter_value;
   } req_beat_type;

   typedef struct packed {
      logic        report_valid;
      logic [15:0] report_delta;
      logic [31:0] time_ms;
   } rsp_beat_type;

   typedef struct packed {
      logic        report_enable;
      logic [31:0] wrap_limit_ms;
   } cfg_type;

   // Elapsed run counts to hundredths of a millisecond
   function automatic hund_lut_type build_run_lut();
      hund_lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = (i <= RUN_RELOAD) ? HUND_WIDTH'((i * HUND_SCALE) / RUN_CLK_HZ) : '0;
      end
      return lut;
   endfunction

   // Elapsed sleep counts to hundredths of a millisecond
   function automatic hund_lut_type build_sleep_lut();
      hund_lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = (i <= SLEEP_RELOAD) ? HUND_WIDTH'((i * HUND_SCALE) / SLEEP_CLK_HZ) : '0;
      end
      return lut;
   endfunction

   localparam hund_lut_type RUN_HUND_LUT   = build_run_lut();
   localparam hund_lut_type SLEEP_HUND_LUT = build_sleep_lut();

endpackage

// ===== rtl/core/tmk_beat_reg.sv =====
// One-entry beat register with valid/ready on both sides.
// Generic; used for the event input and the result output of the timekeeper.
`timescale 1ns / 1ps

module tmk_beat_reg #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);

   logic             valid_ff, valid_in;
   logic [Width-1:0] data_ff;

   // Space when empty or when the held beat leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/tmk_csr.sv =====
// Configuration registers of the timekeeper: report enable and wrap limit.
// Depends on tmk_pkg.
`timescale 1ns / 1ps

module tmk_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic            csr_index,
   input  logic [31:0]     csr_wdata,
   output tmk_pkg::cfg_type cfg
);
   import tmk_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_enable <= 1'b0;
         cfg_ff.wrap_limit_ms <= WRAP_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_REPORT_ENABLE: cfg_ff.report_enable <= csr_wdata[0];
            CSR_WRAP_LIMIT:    cfg_ff.wrap_limit_ms <= csr_wdata;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tmk_update.sv =====
// Clock state and per-event update: tick/switch conversion, wrap, reporting.
// Depends on tmk_pkg and the assertion macros header.
`timescale 1ns / 1ps

module tmk_update (
   input  logic                  clock,
   input  logic                  reset,
   input  tmk_pkg::cfg_type      cfg,
   input  logic                  ev_fire,
   input  tmk_pkg::req_beat_type ev,
   output tmk_pkg::rsp_beat_type result
);
   import tmk_pkg::*;
   `include "tickless_ms_timekeeper_assert.svh"

   logic                  mode_ff, mode_in;
   logic [31:0]           clock_ms_ff, clock_ms_in;
   logic [FRAC_WIDTH-1:0] frac_ff, frac_in;
   logic [31:0]           last_report_ff, last_report_in;

   logic                  is_tick, run_tick;
   logic [7:0]            reload, counter_clamped, elapsed;
   logic [HUND_WIDTH-1:0] lut_hund, base_hund, total_hund;
   logic [26:0]           div_prod;
   logic [7:0]            quot;
   logic [HUND_WIDTH-1:0] quot_x100;
   logic [31:0]           clock_sum, delta_full;

   assign is_tick  = (ev.mode == MODE_TICK);
   assign run_tick = is_tick && (mode_ff == TICK_RUN);

   // Counts elapsed in the old mode, clamped to its reload
   assign reload          = (mode_ff == TICK_RUN) ? RUN_RELOAD_V : SLEEP_RELOAD_V;
   assign counter_clamped = (ev.counter_value > reload) ? reload : ev.counter_value;
   assign elapsed         = reload - counter_clamped;
   assign lut_hund        = (mode_ff == TICK_RUN) ? RUN_HUND_LUT[elapsed]
                                                  : SLEEP_HUND_LUT[elapsed];

   // Hundredths to add; a run tick adds a whole ms directly
   always_comb begin
      if (run_tick) begin
         base_hund = '0;
      end else if (is_tick) begin
         base_hund = SLEEP_TICK_HUND;
      end else begin
         base_hund = lut_hund;
      end
   end

   assign total_hund = base_hund + HUND_WIDTH'(frac_ff);

   // Split into ms and remainder: multiply by reciprocal of 100
   assign div_prod  = 27'(total_hund) * 27'(DIV100_MUL);
   assign quot      = div_prod[26:DIV100_SHIFT];
   assign quot_x100 = HUND_WIDTH'({quot, 6'b0}) + HUND_WIDTH'({quot, 5'b0})
                      + HUND_WIDTH'({quot, 2'b0});

   assign clock_sum  = clock_ms_ff + 32'(quot) + 32'(run_tick);
   assign delta_full = clock_sum - last_report_ff;

   // Next state and result
   always_comb begin
      mode_in        = mode_ff;
      frac_in        = FRAC_WIDTH'(total_hund - quot_x100);
      last_report_in = last_report_ff;
      clock_ms_in    = clock_sum;
      result.report_valid = 1'b0;
      result.report_delta = '0;
      if (is_tick) begin
         if (run_tick && cfg.report_enable) begin
            result.report_valid = 1'b1;
            result.report_delta = 16'd1;
            last_report_in      = clock_sum;
         end
         if (clock_sum > cfg.wrap_limit_ms) begin
            clock_ms_in = '0;
         end
      end else begin
         mode_in = ev.new_mode;
         if ((ev.new_mode == TICK_RUN) && cfg.report_enable) begin
            result.report_valid = 1'b1;
            result.report_delta = delta_full[15:0];
            last_report_in      = clock_sum;
         end
      end
      result.time_ms = clock_ms_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= TICK_RUN;
         clock_ms_ff    <= '0;
         frac_ff        <= '0;
         last_report_ff <= '0;
      end else if (ev_fire) begin
         mode_ff        <= mode_in;
         clock_ms_ff    <= clock_ms_in;
         frac_ff        <= frac_in;
         last_report_ff <= last_report_in;
      end
   end

   // Checks
   `TMK_ASSERT_NOW(a_frac_range, clock, reset, 1'b1, frac_ff < FRAC_WIDTH'(100),
      "remainder left its 0..99 range")
   `TMK_ASSERT_NEXT(a_tick_wrap, clock, reset, ev_fire && is_tick,
      clock_ms_ff <= $past(cfg.wrap_limit_ms), "clock above wrap limit after tick")
   `TMK_ASSERT_NEXT(a_switch_report, clock, reset,
      ev_fire && !is_tick && result.report_valid,
      last_report_ff == clock_ms_ff, "report mark not taken on switch into run")
   `TMK_ASSERT_NOW(a_sleep_quiet, clock, reset, is_tick && (mode_ff == TICK_SLEEP),
      !result.report_valid, "sleep tick produced a report")

endmodule

// ===== rtl/core/tickless_ms_timekeeper.sv =====
// Top level of the tickless millisecond timekeeper.
// Depends on tmk_pkg, tmk_beat_reg, tmk_csr and tmk_update.
//
//   channel | ports                         | carries
//   req     | req_valid/req_ready/req_data  | tick or mode-switch event
//   rsp     | rsp_valid/rsp_ready/rsp_data  | report and clock after event
//   csr     | csr_write_en/index/wdata      | report enable, wrap limit
//
// One event per cycle sustained while rsp is not stalled; a taken beat passes
// through the event register, then the result register, on its way to rsp.
// The update between the two registers is a table lookup, a divide by 100
// through a reciprocal multiply, and a 32-bit add and compare.
// Synchronous reset clears mode, clock, remainder, report mark; config to reset values.
// A stalled rsp side holds one result and still takes one more event.
`timescale 1ns / 1ps

module tickless_ms_timekeeper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tmk_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tmk_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);
   import tmk_pkg::*;

   localparam int ReqWidth = $bits(req_beat_type);
   localparam int RspWidth = $bits(rsp_beat_type);

   cfg_type      cfg;
   req_beat_type ev;
   rsp_beat_type result;
   logic         ev_valid, ev_fire, res_ready;

   tmk_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Event register
   tmk_beat_reg #(.Width(ReqWidth)) u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (ev_valid),
      .out_ready (res_ready),
      .out_data  (ev)
   );

   assign ev_fire = ev_valid && res_ready;

   tmk_update u_update (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .ev_fire (ev_fire),
      .ev      (ev),
      .result  (result)
   );

   // Result register
   tmk_beat_reg #(.Width(RspWidth)) u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ev_valid),
      .in_ready  (res_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the tickless millisecond timekeeper.
// Depends on tmk_pkg and tickless_ms_timekeeper; holds its own clock model and
// drives directed and random tick / mode-switch beats through several CSR settings.
`timescale 1ns / 1ps

module tb_top;
   import tmk_pkg::*;

   localparam int HUND_PER_MS = 100;
   localparam int NUM_PHASES  = 7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_write_en = 1'b0;
   logic         csr_index = CSR_REPORT_ENABLE;
   logic [31:0]  csr_wdata = '0;
   logic         hold_req = 1'b0;

   // Settings walked through, extremes of the wrap limit among them
   logic        phase_en    [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   logic [31:0] phase_limit [NUM_PHASES] = '{32'd4000000000, 32'd1, 32'd1, 32'd57,
                                             32'd1800000, 32'd100000, 32'd4000000000};

   // Clock model and queue of results still owed by the block
   class ms_clock_scoreboard;
      logic            report_en;
      logic [31:0]     wrap_ms;
      logic            cur_mode;
      logic [31:0]     clk_ms;
      logic [6:0]      frac;
      logic [31:0]     mark_ms;
      rsp_beat_type    readings_due[$];
      int              n_errors;

      function new();
         report_en = 1'b0;
         wrap_ms   = WRAP_LIMIT_RESET;
         cur_mode  = TICK_RUN;
         clk_ms    = '0;
         frac      = '0;
         mark_ms   = '0;
         n_errors  = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         if (idx == CSR_REPORT_ENABLE) report_en = value[0];
         else wrap_ms = value;
      endfunction

      function int outstanding();
         return readings_due.size();
      endfunction

      // Fold hundredths plus the carried remainder into the clock
      function void add_hund(longint unsigned h);
         h = h + frac;
         clk_ms = clk_ms + 32'(h / HUND_PER_MS);
         frac   = 7'(h % HUND_PER_MS);
      endfunction

      function rsp_beat_type advance_clock(req_beat_type ev);
         rsp_beat_type    r;
         logic [7:0]      reload;
         logic [7:0]      cnt;
         longint unsigned hund;
         r = '0;
         if (ev.mode == MODE_TICK) begin
            if (cur_mode == TICK_RUN) begin
               clk_ms = clk_ms + 32'd1;
               if (report_en) begin
                  r.report_valid = 1'b1;
                  r.report_delta = 16'd1;
                  mark_ms = clk_ms;
               end
            end else begin
               add_hund(longint'((SLEEP_RELOAD + 1) * HUND_SCALE / SLEEP_CLK_HZ));
            end
            // only ticks wrap; the remainder survives
            if (clk_ms > wrap_ms) clk_ms = '0;
         end else begin
            reload = (cur_mode == TICK_RUN) ? RUN_RELOAD_V : SLEEP_RELOAD_V;
            cnt    = (ev.counter_value > reload) ? reload : ev.counter_value;
            hund   = 64'(reload - cnt);
            hund   = hund * HUND_SCALE / ((cur_mode == TICK_RUN) ? RUN_CLK_HZ : SLEEP_CLK_HZ);
            add_hund(hund);
            cur_mode = ev.new_mode;
            if (ev.new_mode == TICK_RUN && report_en) begin
               r.report_valid = 1'b1;
               r.report_delta = 16'(clk_ms - mark_ms);
               mark_ms = clk_ms;
            end
         end
         r.time_ms = clk_ms;
         return r;
      endfunction

      function void note_event(req_beat_type ev);
         readings_due.push_back(advance_clock(ev));
      endfunction

      task report_mismatch(string what);
         $display("tb_top: mismatch at %0t: %s", $realtime, what);
         n_errors++;
      endtask

      task check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (readings_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %p", got));
         end else begin
            want = readings_due.pop_front();
            if (got.report_valid !== want.report_valid)
               report_mismatch($sformatf("report_valid %b, expected %b",
                                         got.report_valid, want.report_valid));
            if (got.report_delta !== want.report_delta)
               report_mismatch($sformatf("report_delta %0d, expected %0d",
                                         got.report_delta, want.report_delta));
            if (got.time_ms !== want.time_ms)
               report_mismatch($sformatf("time_ms %0d, expected %0d",
                                         got.time_ms, want.time_ms));
         end
      endtask
   endclass

   ms_clock_scoreboard sb;

   tickless_ms_timekeeper uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic req_beat_type make_event(logic m, logic nm, logic [7:0] cnt);
      req_beat_type ev;
      ev.mode          = m;
      ev.new_mode      = nm;
      ev.counter_value = cnt;
      return ev;
   endfunction

   // Random beat: counter mostly within the current reload, some at the ends, some above
   function automatic req_beat_type random_event();
      logic [7:0] reload;
      logic [7:0] cnt;
      int         sel;
      reload = (sb.cur_mode == TICK_RUN) ? RUN_RELOAD_V : SLEEP_RELOAD_V;
      sel = $urandom_range(99);
      if (sel < 10) cnt = 8'($urandom_range(255, int'(reload) + 1));
      else if (sel < 15) cnt = 8'd0;
      else if (sel < 20) cnt = reload;
      else cnt = 8'($urandom_range(int'(reload), 0));
      return make_event(($urandom_range(99) < 55) ? MODE_TICK : MODE_SWITCH,
                        1'($urandom_range(1)), cnt);
   endfunction

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Both registers in consecutive cycles, enable dropped once afterwards
   task automatic write_regs(logic en, logic [31:0] limit);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_REPORT_ENABLE;
      csr_wdata    <= {31'd0, en};
      @(posedge clock);
      sb.set_reg(CSR_REPORT_ENABLE, {31'd0, en});
      csr_index <= CSR_WRAP_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      sb.set_reg(CSR_WRAP_LIMIT, limit);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_item(req_beat_type ev);
      req_data  <= ev;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(ev);
   endtask

   task automatic run_directed();
      req_beat_type evs[$];
      evs = '{make_event(MODE_TICK,   TICK_RUN,   8'd0),
              make_event(MODE_SWITCH, TICK_RUN,   8'd249),   // no counts elapsed
              make_event(MODE_SWITCH, TICK_RUN,   8'd0),     // full run period
              make_event(MODE_SWITCH, TICK_RUN,   8'd250),   // clamped in run
              make_event(MODE_SWITCH, TICK_SLEEP, 8'd255),   // clamped, into sleep
              make_event(MODE_TICK,   TICK_RUN,   8'd0),
              make_event(MODE_TICK,   TICK_SLEEP, 8'd17),
              make_event(MODE_SWITCH, TICK_SLEEP, 8'd0),     // same mode, full sleep
              make_event(MODE_SWITCH, TICK_SLEEP, 8'd59),    // clamped in sleep
              make_event(MODE_SWITCH, TICK_SLEEP, 8'd58),
              make_event(MODE_SWITCH, TICK_RUN,   8'd30),    // back to run, reports
              make_event(MODE_TICK,   TICK_SLEEP, 8'd255),   // tick ignores its fields
              make_event(MODE_SWITCH, TICK_SLEEP, 8'd0),
              make_event(MODE_SWITCH, TICK_RUN,   8'd0),
              make_event(MODE_TICK,   TICK_RUN,   8'd128)};
      foreach (evs[i]) send_item(evs[i]);
   endtask

   // Back-to-back beats, used while the receiver holds off
   task automatic flood(int n);
      for (int i = 0; i < n; i++) send_item(random_event());
   endtask

   // Bursts of random length with random gaps; optional drain halfway through
   task automatic run_random(int n, bit pause);
      int burst;
      int gap;
      burst = $urandom_range(24, 1);
      for (int i = 0; i < n; i++) begin
         if (pause && i == n / 2) begin
            req_valid <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         send_item(random_event());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(24, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Receiver: checks each result beat, stalls on segments of random density
   initial begin
      int   hold_left;
      int   seg_left;
      int   stall_pct;
      logic hold_done;
      hold_left = 0;
      seg_left  = 0;
      stall_pct = 0;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         // one long hold, started once when asked for
         if (hold_req && !hold_done) begin
            hold_left = 150;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(80, 16);
               case ($urandom_range(4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 20;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            seg_left--;
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Main sequence
   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         write_regs(phase_en[p], phase_limit[p]);
         if (p == 0) run_directed();
         if (p == 2) begin
            // long receiver hold while beats keep coming, so the input backs up
            hold_req <= 1'b1;
            flood(30);
         end
         run_random(140, p == 4);
         req_valid <= 1'b0;
      end
      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.n_errors == 0 && sb.outstanding() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
